// File: design/eitp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eitp_pkg: shared types and constants of the EIT section parser
// Record kinds, parse phases, register indexes and the result record type.
// ----------------------------------------------------------------------------
package eitp_pkg;

    localparam int MAX_SECTION_BYTES_DEF = 4096;
    localparam int POS_W = 13;

    typedef enum logic [1:0] {
        KIND_HDR = 2'd0,
        KIND_EVT = 2'd1,
        KIND_DSC = 2'd2,
        KIND_END = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_EVENT_LIMIT = 2'd0,
        REG_DESC_LIMIT  = 2'd1,
        REG_MIN_BYTES   = 2'd2,
        REG_MAX_BYTES   = 2'd3
    } t_reg;

    typedef enum logic [7:0] {
        PH_HDR    = 8'b0000_0001,
        PH_BOUND  = 8'b0000_0010,
        PH_EVT    = 8'b0000_0100,
        PH_DBOUND = 8'b0000_1000,
        PH_DHDR   = 8'b0001_0000,
        PH_DBODY  = 8'b0010_0000,
        PH_DREST  = 8'b0100_0000,
        PH_TRAIL  = 8'b1000_0000
    } t_phase;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_CRC = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  w1;
        logic [15:0]  w2;
        logic [15:0]  w3;
        logic [39:0]  wide;
        logic [23:0]  dur;
        logic [7:0]   tid;
        logic [4:0]   aux;
        logic         flag;
        logic         last;
    } t_rec;

    // Up to two records caused by one byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_rec       r0;
        t_rec       r1;
    } t_pair;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {b, 24'd0};
        for (int i = 0; i < 8; i++)
            c = c[31] ? ((c << 1) ^ 32'h04C1_1DB7) : (c << 1);
        return c;
    endfunction

endpackage

// File: design/eit_section_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_section_parser: DVB EIT section parser
// Byte-serial parse of an event information section into header, event,
// descriptor and summary records, with CRC-32/MPEG-2 check.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata = data_byte[7:0], tlast = last_byte
// m_axis    out  tdata = words and values, tuser = record_kind, tlast = last_record
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, one register per write
//
// One byte request is taken per cycle unless input stalls; a byte yields at
// most two records, offered on m_axis once the records ahead have left.
// The records go through a four-entry queue; input stalls when the queue,
// counting a record leaving in the same cycle, lacks room for two more,
// which happens only after the output side has stalled.
// Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module eit_section_parser #(
    parameter int MAX_SECTION_BYTES = eitp_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [12:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // first_word[15:0], second_word[31:16], third_word[47:32],
    // wide_value[87:48], event_duration[111:88], tbl_id[119:112],
    // small_field[124:120], flag_bit[125], zeros to 127
    output logic [127:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // record_kind
    output logic         m_axis_tlast    // last_record
);
    import eitp_pkg::*;

    t_pair w_pair;
    t_rec  w_rec;
    logic  w_take;

    // A byte is taken only when the queue can hold both records it may cause.
    assign w_take = s_axis_tvalid && s_axis_tready;

    eitp_front #(.MAX_BYTES(MAX_SECTION_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_take(w_take), .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .o_pair(w_pair)
    );

    eitp_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(w_take), .i_pair(w_pair),
        .o_room(s_axis_tready), .o_valid(m_axis_tvalid), .o_rec(w_rec),
        .i_rd(m_axis_tready)
    );

    assign m_axis_tdata = {2'd0, w_rec.flag, w_rec.aux, w_rec.tid, w_rec.dur,
                           w_rec.wide, w_rec.w3, w_rec.w2, w_rec.w1};
    assign m_axis_tuser = w_rec.kind;
    assign m_axis_tlast = w_rec.last;
endmodule

// File: design/eitp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eitp_front: byte parser
// Walks the section one byte per cycle unless stalled and forms its records.
// ----------------------------------------------------------------------------
module eitp_front #(
    parameter int MAX_BYTES = eitp_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output eitp_pkg::t_pair     o_pair
);
    import eitp_pkg::*;

    logic [7:0]  r_ev_lim, r_ds_lim;
    logic [12:0] r_min, r_max;
    logic [12:0] r_pos, n_pos;
    t_phase      r_ph, n_ph;
    logic [11:0] r_dlen, n_dlen;
    logic signed [14:0] r_ebl, n_ebl;
    logic [7:0]  r_ecnt, n_ecnt, r_dcnt, n_dcnt;
    logic [13:0] r_dbl, n_dbl;
    logic [8:0]  r_skip, n_skip;
    logic [63:0] r_fa0, n_fa0, r_fa1, n_fa1, r_h0, n_h0, r_h1, n_h1;
    logic [31:0] r_crc, n_crc, r_rx, n_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_lim <= 8'd64;
            r_ds_lim <= 8'd32;
            r_min    <= 13'd18;
            r_max    <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EVENT_LIMIT: r_ev_lim <= i_cfg_data[7:0];
                REG_DESC_LIMIT:  r_ds_lim <= i_cfg_data[7:0];
                REG_MIN_BYTES:   r_min    <= i_cfg_data;
                REG_MAX_BYTES:   r_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        t_rec r;
        logic [8:0] b;
        logic [11:0] dll;
        logic [7:0] b10, b5;
        logic [12:0] tot;
        logic [1:0] st;
        n_pos = r_pos; n_ph = r_ph; n_dlen = r_dlen; n_ebl = r_ebl;
        n_ecnt = r_ecnt; n_dcnt = r_dcnt; n_dbl = r_dbl; n_skip = r_skip;
        n_fa0 = r_fa0; n_fa1 = r_fa1; n_h0 = r_h0; n_h1 = r_h1;
        n_crc = r_crc; n_rx = r_rx;
        o_pair = '0;
        r = '0; dll = '0; b10 = '0; b5 = '0; st = ST_OK;
        b = {1'b0, i_byte};
        if (r_pos >= 13'd4) n_crc = crc_byte(r_crc, r_rx[31:24]);
        n_rx = {r_rx[23:0], i_byte};
        if (r_pos != 13'h1FFF) n_pos = r_pos + 13'd1;
        tot = n_pos;
        if (r_ph == PH_HDR) begin
            if (r_pos < 13'd8) n_h0 = {r_h0[55:0], i_byte};
            else n_h1 = {r_h1[55:0], i_byte};
            if (r_pos == 13'd13) begin
                b5 = n_h0[23:16];
                n_dlen = n_h0[51:40];
                n_ebl = $signed({3'd0, n_dlen}) - 15'sd15;
                n_ph = PH_BOUND;
                r = '0;
                r.kind = KIND_HDR;
                r.w1 = n_h0[39:24];
                r.w2 = n_h1[47:32];
                r.w3 = n_h1[31:16];
                r.wide = {8'd0, n_h0[15:8], n_h0[7:0], n_h1[15:8], n_h1[7:0]};
                r.tid = n_h0[63:56];
                r.aux = b5[5:1];
                r.flag = b5[0];
                o_pair.r0 = r;
                o_pair.cnt = 2'd1;
            end
        end else begin
            if (n_ph == PH_BOUND) begin
                if (r_ebl >= 15'sd12 && r_ecnt < r_ev_lim) begin
                    n_ph = PH_EVT; n_skip = '0;
                end else n_ph = PH_TRAIL;
            end
            if (n_ph == PH_DBOUND) begin
                if (r_dbl >= 14'd2 && r_dcnt < r_ds_lim) begin
                    n_fa1 = {40'd0, i_byte, 3'd0, r_pos};
                    n_dbl = r_dbl - 14'd1;
                    n_ph = PH_DHDR;
                    b = 9'h100;
                end else n_ph = PH_DREST;
            end
            case (n_ph)
                PH_EVT: begin
                    if (n_skip < 9'd8) n_fa0 = {n_fa0[55:0], i_byte};
                    else n_fa1 = {32'd0, n_fa1[23:0], i_byte};
                    n_skip = n_skip + 9'd1;
                    if (n_skip >= 9'd12) begin
                        b10 = n_fa1[15:8];
                        dll = {b10[3:0], n_fa1[7:0]};
                        r = '0;
                        r.kind = KIND_EVT;
                        r.w1 = n_fa0[63:48];
                        r.w2 = {4'd0, dll};
                        r.wide = n_fa0[47:8];
                        r.dur = {n_fa0[7:0], n_fa1[31:16]};
                        r.aux = {2'd0, b10[7:5]};
                        r.flag = b10[4];
                        o_pair.r0 = r;
                        o_pair.cnt = 2'd1;
                        n_ecnt = r_ecnt + 8'd1;
                        n_ebl = r_ebl - $signed({3'd0, dll}) - 15'sd12;
                        n_dbl = {2'd0, dll};
                        n_dcnt = '0;
                        n_skip = '0;
                        n_ph = (dll != 12'd0) ? PH_DBOUND : PH_BOUND;
                    end
                end
                PH_DHDR: begin
                    if (!b[8]) begin
                        n_dbl = r_dbl - 14'd1;
                        n_dcnt = r_dcnt + 8'd1;
                        r = '0;
                        r.kind = KIND_DSC;
                        r.w1 = {8'd0, r_fa1[23:16]};
                        r.w2 = {8'd0, i_byte};
                        r.w3 = r_fa1[15:0];
                        o_pair.r0 = r;
                        o_pair.cnt = 2'd1;
                        n_skip = {1'b0, i_byte};
                        if (n_dbl == 14'd0) n_ph = PH_BOUND;
                        else if (i_byte == 8'd0) n_ph = PH_DBOUND;
                        else n_ph = PH_DBODY;
                    end
                end
                PH_DBODY: begin
                    n_dbl = r_dbl - 14'd1;
                    n_skip = r_skip - 9'd1;
                    if (n_dbl == 14'd0) n_ph = PH_BOUND;
                    else if (n_skip == 9'd0) n_ph = PH_DBOUND;
                end
                PH_DREST: begin
                    n_dbl = r_dbl - 14'd1;
                    if (n_dbl == 14'd0) n_ph = PH_BOUND;
                end
                default: ;
            endcase
        end
        if (i_last) begin
            if (tot < r_min || tot > r_max || 32'(tot) > 32'(MAX_BYTES) ||
                tot < 13'd18 || tot != ({1'b0, n_dlen} + 13'd3))
                st = ST_LEN;
            else if (n_crc != n_rx)
                st = ST_CRC;
            r = '0;
            r.kind = KIND_END;
            r.w1 = {8'd0, n_ecnt};
            r.w2 = {14'd0, st};
            r.wide = {8'd0, n_rx};
            if (o_pair.cnt == 2'd1) o_pair.r1 = r;
            else o_pair.r0 = r;
            o_pair.cnt = o_pair.cnt + 2'd1;
            n_pos = '0; n_ph = PH_HDR; n_dlen = '0; n_ebl = '0; n_ecnt = '0;
            n_dcnt = '0; n_dbl = '0; n_skip = '0; n_fa0 = '0; n_fa1 = '0;
            n_h0 = '0; n_h1 = '0; n_crc = '1; n_rx = '0;
        end
        if (o_pair.cnt == 2'd1) o_pair.r0.last = 1'b1;
        if (o_pair.cnt == 2'd2) o_pair.r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ph <= PH_HDR; r_dlen <= '0; r_ebl <= '0; r_ecnt <= '0;
            r_dcnt <= '0; r_dbl <= '0; r_skip <= '0; r_fa0 <= '0; r_fa1 <= '0;
            r_h0 <= '0; r_h1 <= '0; r_crc <= '1; r_rx <= '0;
        end else if (i_take) begin
            r_pos <= n_pos; r_ph <= n_ph; r_dlen <= n_dlen; r_ebl <= n_ebl;
            r_ecnt <= n_ecnt; r_dcnt <= n_dcnt; r_dbl <= n_dbl; r_skip <= n_skip;
            r_fa0 <= n_fa0; r_fa1 <= n_fa1; r_h0 <= n_h0; r_h1 <= n_h1;
            r_crc <= n_crc; r_rx <= n_rx;
        end
    end

`ifndef ASSERT_OFF
    a_pos_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_HDR) |-> (r_pos <= 13'd13))
        else $error("header phase past byte 13");
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> (r_pos == 13'd0 && r_crc == 32'hFFFF_FFFF))
        else $error("state not cleared after last byte");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pair.cnt != 2'd3)
        else $error("too many records for one byte");
`endif
endmodule

// File: design/eitp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eitp_queue: record queue
// Four-entry queue of records between the parser and the output port.
// ----------------------------------------------------------------------------
module eitp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  eitp_pkg::t_pair  i_pair,
    output logic             o_room,
    output logic             o_valid,
    output eitp_pkg::t_rec   o_rec,
    input  logic             i_rd
);
    import eitp_pkg::*;

    t_rec       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] n_add;
    logic       w_rd;

    assign w_rd    = i_rd && (r_cnt != 3'd0);
    assign n_add   = i_wr ? i_pair.cnt : 2'd0;
    assign o_room  = (r_cnt <= 3'd2) || (r_cnt == 3'd3 && i_rd);
    assign o_valid = (r_cnt != 3'd0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (n_add != 2'd0) r_mem[r_wp] <= i_pair.r0;
        if (n_add == 2'd2) r_mem[r_wp + 2'd1] <= i_pair.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_add;
            r_rp  <= r_rp + {1'b0, w_rd};
            r_cnt <= r_cnt + {1'b0, n_add} - {2'd0, w_rd};
        end
    end

`ifndef ASSERT_OFF
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overflow");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !o_room) |-> (i_pair.cnt == 2'd0)) else $error("write without room");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0 && !i_wr) |=> !o_valid) else $error("phantom record");
`endif
endmodule

// File: sim/eit_section_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_section_checker: record predictor and scoreboard for the EIT parser
// Watches the register port and both streams, parses every accepted byte
// request the way the parser must, and compares each record leaving the block
// with the oldest record predicted.
// ----------------------------------------------------------------------------
module eit_section_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [12:0]  i_cfg_data,
    input  logic         i_byte_valid,
    input  logic         i_byte_ready,
    input  logic [7:0]   i_byte_data,
    input  logic         i_byte_last,
    input  logic         i_rec_valid,
    input  logic         i_rec_ready,
    input  logic [127:0] i_rec_data,
    input  logic [1:0]   i_rec_kind,
    input  logic         i_rec_last,
    output int           o_errors,
    output int           o_pending
);
    import eitp_pkg::*;

    // Register copies.
    int unsigned lim_evt, lim_dsc, min_bytes, max_bytes;

    // Parser state.
    int unsigned pos_cnt, sec_len, evt_cnt, dsc_left, dsc_cnt, run_cnt;
    int          loop_left;
    t_phase      phase;
    logic [63:0] evt_acc0, evt_acc1, hdr_acc0, hdr_acc1;
    logic [31:0] crc_acc, crc_tail;

    t_rec expected_recs[$];

    assign o_pending = expected_recs.size();

    task automatic clear_parse();
        pos_cnt = 0;  phase = PH_HDR;  sec_len = 0;  loop_left = 0;
        evt_cnt = 0;  dsc_left = 0;  dsc_cnt = 0;  run_cnt = 0;
        evt_acc0 = '0;  evt_acc1 = '0;  hdr_acc0 = '0;  hdr_acc1 = '0;
        crc_acc = 32'hFFFF_FFFF;  crc_tail = '0;
    endtask

    // Parses one accepted byte and queues the records it must produce.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int unsigned here, dll, total;
        logic        tag_taken;
        logic [7:0]  b5, b10;
        logic [1:0]  status;
        t_rec        r;
        int          first_new;
        here = pos_cnt;
        tag_taken = 1'b0;
        first_new = expected_recs.size();
        // CRC runs four bytes behind; the tail holds the last four bytes.
        if (here >= 4) begin
            crc_acc ^= {crc_tail[31:24], 24'd0};
            for (int i = 0; i < 8; i++)
                crc_acc = crc_acc[31] ? ((crc_acc << 1) ^ 32'h04C1_1DB7) : (crc_acc << 1);
        end
        crc_tail = {crc_tail[23:0], b};
        if (pos_cnt < 8191) pos_cnt++;

        if (phase == PH_HDR) begin
            if (here < 8) hdr_acc0 = {hdr_acc0[55:0], b};
            else hdr_acc1 = {hdr_acc1[55:0], b};
            if (here == 13) begin
                b5 = hdr_acc0[23:16];
                sec_len = hdr_acc0[51:40];
                loop_left = int'(sec_len) - 15;
                phase = PH_BOUND;
                r = '0;
                r.kind = KIND_HDR;
                r.w1 = hdr_acc0[39:24];
                r.w2 = hdr_acc1[47:32];
                r.w3 = hdr_acc1[31:16];
                r.wide = {8'd0, hdr_acc0[15:8], hdr_acc0[7:0], hdr_acc1[15:8], hdr_acc1[7:0]};
                r.tid = hdr_acc0[63:56];
                r.aux = b5[5:1];
                r.flag = b5[0];
                expected_recs.push_back(r);
            end
        end else begin
            if (phase == PH_BOUND) begin
                if (loop_left >= 12 && evt_cnt < lim_evt) begin
                    phase = PH_EVT;
                    run_cnt = 0;
                end else begin
                    phase = PH_TRAIL;
                end
            end
            // A descriptor's tag byte is taken here and not parsed further.
            if (phase == PH_DBOUND) begin
                if (dsc_left >= 2 && dsc_cnt < lim_dsc) begin
                    evt_acc1 = {40'd0, b, here[15:0]};
                    dsc_left--;
                    phase = PH_DHDR;
                    tag_taken = 1'b1;
                end else begin
                    phase = PH_DREST;
                end
            end
            case (phase)
                PH_EVT: begin
                    if (run_cnt < 8) evt_acc0 = {evt_acc0[55:0], b};
                    else evt_acc1 = {32'd0, evt_acc1[23:0], b};
                    run_cnt++;
                    if (run_cnt >= 12) begin
                        b10 = evt_acc1[15:8];
                        dll = {b10[3:0], evt_acc1[7:0]};
                        r = '0;
                        r.kind = KIND_EVT;
                        r.w1 = evt_acc0[63:48];
                        r.w2 = dll[15:0];
                        r.wide = evt_acc0[47:8];
                        r.dur = {evt_acc0[7:0], evt_acc1[31:16]};
                        r.aux = {2'd0, b10[7:5]};
                        r.flag = b10[4];
                        expected_recs.push_back(r);
                        evt_cnt++;
                        loop_left -= 12 + int'(dll);
                        dsc_left = dll;
                        dsc_cnt = 0;
                        run_cnt = 0;
                        phase = (dll != 0) ? PH_DBOUND : PH_BOUND;
                    end
                end
                PH_DHDR: begin
                    if (!tag_taken) begin
                        dsc_left--;
                        dsc_cnt++;
                        r = '0;
                        r.kind = KIND_DSC;
                        r.w1 = {8'd0, evt_acc1[23:16]};
                        r.w2 = {8'd0, b};
                        r.w3 = evt_acc1[15:0];
                        expected_recs.push_back(r);
                        run_cnt = b;
                        if (dsc_left == 0) phase = PH_BOUND;
                        else if (b == 0) phase = PH_DBOUND;
                        else phase = PH_DBODY;
                    end
                end
                PH_DBODY: begin
                    dsc_left--;
                    run_cnt--;
                    if (dsc_left == 0) phase = PH_BOUND;
                    else if (run_cnt == 0) phase = PH_DBOUND;
                end
                PH_DREST: begin
                    dsc_left--;
                    if (dsc_left == 0) phase = PH_BOUND;
                end
                default: ;
            endcase
        end

        if (last) begin
            total = pos_cnt;
            if (total < min_bytes || total > max_bytes || total > MAX_SECTION_BYTES_DEF ||
                total < 18 || total != sec_len + 3)
                status = ST_LEN;
            else if (crc_acc != crc_tail)
                status = ST_CRC;
            else
                status = ST_OK;
            r = '0;
            r.kind = KIND_END;
            r.w1 = {8'd0, evt_cnt[7:0]};
            r.w2 = {14'd0, status};
            r.wide = {8'd0, crc_tail};
            expected_recs.push_back(r);
            clear_parse();
        end
        if (expected_recs.size() > first_new)
            expected_recs[expected_recs.size() - 1].last = 1'b1;
    endtask

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rec want;
        if (!i_rst_n) begin
            lim_evt = 64;  lim_dsc = 32;  min_bytes = 18;  max_bytes = 4096;
            clear_parse();
            expected_recs.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_EVENT_LIMIT: lim_evt = i_cfg_data[7:0];
                    REG_DESC_LIMIT:  lim_dsc = i_cfg_data[7:0];
                    REG_MIN_BYTES:   min_bytes = i_cfg_data;
                    REG_MAX_BYTES:   max_bytes = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_byte_valid && i_byte_ready) parse_byte(i_byte_data, i_byte_last);
            if (i_rec_valid && i_rec_ready) begin
                if (expected_recs.size() == 0) begin
                    $display("%0t: unexpected record, expected none, actual kind %0d data %0h",
                             $time, i_rec_kind, i_rec_data);
                    o_errors++;
                end else begin
                    want = expected_recs.pop_front();
                    report("record_kind", want.kind, i_rec_kind);
                    report("first_word", want.w1, i_rec_data[15:0]);
                    report("second_word", want.w2, i_rec_data[31:16]);
                    report("third_word", want.w3, i_rec_data[47:32]);
                    report("wide_value", want.wide, i_rec_data[87:48]);
                    report("event_duration", want.dur, i_rec_data[111:88]);
                    report("tbl_id", want.tid, i_rec_data[119:112]);
                    report("small_field", want.aux, i_rec_data[124:120]);
                    report("flag_bit", want.flag, i_rec_data[125]);
                    report("last_record", want.last, i_rec_last);
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

// File: sim/tb_eit_section_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eit_section_parser: regression bench for the EIT section parser
// Feeds well-formed sections with random content, corrupted and truncated
// sections and plain noise under several register settings and stall
// patterns; a separate checker predicts and compares every record.
// ----------------------------------------------------------------------------
module tb_eit_section_parser;
    import eitp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [12:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;   // data_byte
    logic         s_axis_tlast = 1'b0; // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // first_word, second_word, third_word, wide_value, event_duration,
    // tbl_id, small_field, flag_bit, from the lowest bit up
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;        // record_kind
    logic         m_axis_tlast;        // last_record

    int errors, pending;
    int send_idle_pct, recv_idle_pct;
    int bytes_sent;
    int cycles;
    logic [7:0] sec_q[$];

    always #1 i_clk = ~i_clk;

    eit_section_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    eit_section_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_byte_valid(s_axis_tvalid), .i_byte_ready(s_axis_tready),
        .i_byte_data(s_axis_tdata), .i_byte_last(s_axis_tlast),
        .i_rec_valid(m_axis_tvalid), .i_rec_ready(m_axis_tready),
        .i_rec_data(m_axis_tdata), .i_rec_kind(m_axis_tuser), .i_rec_last(m_axis_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver stalls at random with the rate of the current phase.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one byte request, idling first at random, and waits until it is taken.
    // The request stays offered afterwards; the caller drives the next one at once
    // or drops tvalid.
    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_section();
        foreach (sec_q[i]) put_byte(sec_q[i], i == sec_q.size() - 1);
    endtask

    // Waits for every predicted record, then for work that
    // produces no record, so a register write finds the block idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_reg idx, input int unsigned val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[12:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_limits(input int unsigned ev, input int unsigned ds,
                              input int unsigned lo, input int unsigned hi);
        set_reg(REG_EVENT_LIMIT, ev);
        set_reg(REG_DESC_LIMIT, ds);
        set_reg(REG_MIN_BYTES, lo);
        set_reg(REG_MAX_BYTES, hi);
    endtask

    // Appends the CRC-32/MPEG-2 of everything queued so far.
    task automatic append_crc();
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        foreach (sec_q[i]) begin
            c ^= {sec_q[i], 24'd0};
            for (int k = 0; k < 8; k++) c = c[31] ? ((c << 1) ^ 32'h04C1_1DB7) : (c << 1);
        end
        for (int k = 3; k >= 0; k--) sec_q.push_back(c[8*k +: 8]);
    endtask

    // Builds a section with n_evt events of up to max_dsc descriptors each.
    // The length field and CRC are right unless a corruption is asked for:
    // 1 flips a CRC bit, 2 skews the length field, 3 truncates the section,
    // 4 gives random event loop bytes behind a right header.
    task automatic build_section(input int n_evt, input int max_dsc, input int flaw);
        int unsigned len, dll, nd, dl, cut;
        logic [7:0] dq[$];
        sec_q = {};
        sec_q.push_back(8'($urandom));
        sec_q.push_back(8'h00);
        sec_q.push_back(8'h00);
        for (int i = 0; i < 11; i++) sec_q.push_back(8'($urandom));
        for (int e = 0; e < n_evt; e++) begin
            dq = {};
            if (flaw == 4) begin
                for (int i = 0; i < $urandom_range(8, 30); i++) sec_q.push_back(8'($urandom));
            end else begin
                nd = $urandom_range(0, max_dsc);
                for (int d = 0; d < nd; d++) begin
                    dl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                    dq.push_back(8'($urandom));
                    dq.push_back(dl[7:0]);
                    for (int i = 0; i < dl; i++) dq.push_back(8'($urandom));
                end
                dll = dq.size();
                for (int i = 0; i < 11; i++) sec_q.push_back(8'($urandom));
                sec_q[sec_q.size() - 1] = {sec_q[sec_q.size() - 1][7:4], dll[11:8]};
                sec_q.push_back(dll[7:0]);
                foreach (dq[i]) sec_q.push_back(dq[i]);
            end
        end
        len = sec_q.size() + 1;
        if (flaw == 2) len = len + $urandom_range(1, 3) - 2 * $urandom_range(0, 1) * 2;
        sec_q[1] = {sec_q[1][7:4], len[11:8]};
        sec_q[2] = len[7:0];
        append_crc();
        if (flaw == 1) sec_q[sec_q.size() - 1 - $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        if (flaw == 3) begin
            cut = $urandom_range(1, sec_q.size() - 1);
            while (sec_q.size() > cut) void'(sec_q.pop_back());
        end
    endtask

    task automatic build_noise(input int n);
        sec_q = {};
        for (int i = 0; i < n; i++) sec_q.push_back(8'($urandom));
    endtask

    // Mostly well-formed sections with random content, some broken, some noise.
    task automatic random_run(input int budget);
        int start, pick;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 60)      build_section($urandom_range(0, 4), 3, 0);
            else if (pick < 90) build_section($urandom_range(0, 4), 3, $urandom_range(1, 4));
            else                build_noise($urandom_range(1, 40));
            send_section();
        end
    endtask

    initial begin
        cycles = 0;
        bytes_sent = 0;
        send_idle_pct = 10;
        recv_idle_pct = 58;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at register defaults: empty event loop at the
        // smallest legal size, a section shorter than its header, a
        // lone end byte, full sections, a CRC error and a length error.
        build_section(0, 0, 0);      send_section();
        build_noise(5);              send_section();
        build_noise(1);              send_section();
        build_section(2, 3, 0);      send_section();
        build_section(1, 2, 1);      send_section();
        build_section(1, 1, 2);      send_section();
        sec_q = {8'h4E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_section();
        build_section(0, 0, 0);
        sec_q[0] = 8'h00;
        send_section();
        random_run(30);

        // Tight limits: no events, at most one event and descriptor, then two events.
        send_idle_pct = 58;
        recv_idle_pct = 10;
        set_limits(0, 0, 0, 0);
        random_run(15);
        set_limits(1, 1, 18, 60);
        random_run(25);
        set_limits(2, 0, 30, 4096);
        random_run(15);

        // Widest limits and no stalls; every section is below the smallest size.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(255, 255, 4096, 4096);
        build_section(2, 3, 0);      send_section();
        build_noise(20);             send_section();
        set_limits(64, 32, 18, 4096);
        random_run(30);

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
